// File: sv/msci_pkg.sv
// Shared types, constants and command codes for the music sequence command interpreter.
// Used by msci_step, the top level and the port checker; depends on nothing else.
package msci_pkg;

   // Field widths
   localparam int ADDR_W   = 16;
   localparam int TICK_W   = 17;
   localparam int LEN_W    = 15;
   localparam int NOTE_W   = 7;
   localparam int PROG_W   = 7;
   localparam int RCNT_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // Fixed values of the sequence format
   localparam logic [ADDR_W-1:0] RAM_PTR_BASE   = 16'hD900;
   localparam logic [TICK_W-1:0] DELAY_MAX      = 17'h1FFFF;
   localparam logic [RCNT_W-1:0] REP_INACTIVE   = 9'h100;
   localparam logic [1:0]        NOISE_TRACK    = 2'd3;
   localparam logic [3:0]        NOISE_MIDI_CH  = 4'd9;
   localparam logic [ADDR_W-1:0] NOISE_OCTAVE   = 16'd36;
   localparam logic [ADDR_W-1:0] OCTAVE_STEP    = 16'd12;
   localparam logic [7:0]        PROG_LIMIT     = 8'h80;

   // Configuration reset values
   localparam logic [ADDR_W-1:0] BANK_BASE_RESET  = 16'd16384;
   localparam logic [ADDR_W-1:0] RAM_BASE_RESET   = 16'd0;
   localparam logic [TICK_W-1:0] TIME_LIMIT_RESET = 17'd110000;

   // Item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_CMD   = 1'b1;

   // Command codes
   localparam logic [7:0] OP_REST_FIRST  = 8'hC0;
   localparam logic [7:0] OP_REST_LAST   = 8'hCF;
   localparam logic [7:0] OP_OCT_SET_END = 8'hD6;
   localparam logic [7:0] OP_OCT_UP      = 8'hD7;
   localparam logic [7:0] OP_OCT_DOWN    = 8'hD8;
   localparam logic [7:0] OP_TRANSPOSE   = 8'hD9;
   localparam logic [7:0] OP_OCT_ADJUST  = 8'hDA;
   localparam logic [7:0] OP_SPEED       = 8'hE0;
   localparam logic [7:0] OP_DUTY        = 8'hE2;
   localparam logic [7:0] OP_SKIP1       = 8'hE8;
   localparam logic [7:0] OP_REP_OPEN    = 8'hF0;
   localparam logic [7:0] OP_REP_CLOSE   = 8'hF1;
   localparam logic [7:0] OP_CALL        = 8'hF2;
   localparam logic [7:0] OP_RETURN      = 8'hF3;
   localparam logic [7:0] OP_END         = 8'hF8;
   localparam logic [7:0] OP_END_ALT     = 8'hFF;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BANK_BASE  = 2'd0,
      CSR_RAM_BASE   = 2'd1,
      CSR_NES_MODE   = 2'd2,
      CSR_TIME_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] bank_base;
      logic [ADDR_W-1:0] ram_base;
      logic              nes_mode;
      logic [TICK_W-1:0] time_limit;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        channel;
      logic              new_song;
      logic [ADDR_W-1:0] start_pointer;
      logic [7:0]        op_byte;
      logic [7:0]        arg_low;
      logic [7:0]        arg_high;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]            position;
      logic [ADDR_W-1:0]            octave_offset;
      logic [ADDR_W-1:0]            octave_adjust;
      logic [7:0]                   transpose_amount;
      logic [7:0]                   speed_factor;
      logic [TICK_W-1:0]            pending_delay;
      logic [TICK_W-1:0]            elapsed_ticks;
      logic                         first_flag;
      logic [PROG_W-1:0]            program_number;
      logic [1:0][RCNT_W-1:0]       repeat_count;
      logic [1:0][ADDR_W-1:0]       repeat_point;
      logic [1:0]                   macro_level;
      logic [1:0][ADDR_W-1:0]       macro_return;
      logic                         ram_mode;
      logic [1:0]                   track_index;
      logic                         ended;
   } chan_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] fetch_address;
      logic              note_valid;
      logic [NOTE_W-1:0] note_number;
      logic [LEN_W-1:0]  note_length;
      logic [TICK_W-1:0] delay_before;
      logic              program_first;
      logic [PROG_W-1:0] instrument;
      logic [3:0]        midi_channel;
      logic              track_end;
   } result_type;

   localparam chan_state_type STATE_RESET = '{
      position:         '0,
      octave_offset:    '0,
      octave_adjust:    '0,
      transpose_amount: '0,
      speed_factor:     8'd1,
      pending_delay:    '0,
      elapsed_ticks:    '0,
      first_flag:       1'b1,
      program_number:   '0,
      repeat_count:     {REP_INACTIVE, REP_INACTIVE},
      repeat_point:     '0,
      macro_level:      '0,
      macro_return:     '0,
      ram_mode:         1'b0,
      track_index:      '0,
      ended:            1'b1
   };

endpackage

// File: sv/music_sequence_command_interpreter_top.sv
// Top level of the music sequence command interpreter: handshakes, registers, config.
// Depends on msci_pkg and msci_step.
//
//   port group | direction | handshake         | carries
//   req_*      | in        | req_valid/stall   | start item or command bytes
//   rsp_*      | out       | rsp_valid/stall   | next fetch address, note event
//   csr_*      | in        | csr_valid/ready   | register index and write data
//
// One request per cycle unless a stalled result backs up the request register.
// The request register feeds msci_step, which updates the channel state and the
// result register in the same cycle, so consecutive commands chain without gaps.
// Reset (synchronous) restores the channel state and config registers to defaults.
// A stalled result holds; one further request is buffered, then req_stall rises.
module music_sequence_command_interpreter_top
   import msci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [1:0]            req_channel,
   input  logic                  req_new_song,
   input  logic [ADDR_W-1:0]     req_start_pointer,
   input  logic [7:0]            req_op_byte,
   input  logic [7:0]            req_arg_low,
   input  logic [7:0]            req_arg_high,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_W-1:0]     rsp_fetch_address,
   output logic                  rsp_note_valid,
   output logic [NOTE_W-1:0]     rsp_note_number,
   output logic [LEN_W-1:0]      rsp_note_length,
   output logic [TICK_W-1:0]     rsp_delay_before,
   output logic                  rsp_program_first,
   output logic [PROG_W-1:0]     rsp_instrument,
   output logic [3:0]            rsp_midi_channel,
   output logic                  rsp_track_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type        cfg_ff, cfg_in;
   item_type       item_ff;
   logic           item_vld_ff, item_vld_in;
   chan_state_type state_ff, state_in;
   result_type     result_ff, result_in;
   logic           rsp_vld_ff, rsp_vld_in;
   logic           req_take;
   logic           advance;

   // Pipeline flow control
   assign advance     = item_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall   = item_vld_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign item_vld_in = req_take || (item_vld_ff && !advance);
   assign rsp_vld_in  = advance || (rsp_vld_ff && rsp_stall);

   // Config writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BANK_BASE:  cfg_in.bank_base  = csr_data[ADDR_W-1:0];
            CSR_RAM_BASE:   cfg_in.ram_base   = csr_data[ADDR_W-1:0];
            CSR_NES_MODE:   cfg_in.nes_mode   = csr_data[0];
            CSR_TIME_LIMIT: cfg_in.time_limit = csr_data[TICK_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   msci_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bank_base  <= BANK_BASE_RESET;
         cfg_ff.ram_base   <= RAM_BASE_RESET;
         cfg_ff.nes_mode   <= 1'b0;
         cfg_ff.time_limit <= TIME_LIMIT_RESET;
         item_vld_ff       <= 1'b0;
         rsp_vld_ff        <= 1'b0;
         state_ff          <= STATE_RESET;
      end else begin
         cfg_ff      <= cfg_in;
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind          <= req_kind;
         item_ff.channel       <= req_channel;
         item_ff.new_song      <= req_new_song;
         item_ff.start_pointer <= req_start_pointer;
         item_ff.op_byte       <= req_op_byte;
         item_ff.arg_low       <= req_arg_low;
         item_ff.arg_high      <= req_arg_high;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_fetch_address = result_ff.fetch_address;
   assign rsp_note_valid    = result_ff.note_valid;
   assign rsp_note_number   = result_ff.note_number;
   assign rsp_note_length   = result_ff.note_length;
   assign rsp_delay_before  = result_ff.delay_before;
   assign rsp_program_first = result_ff.program_first;
   assign rsp_instrument    = result_ff.instrument;
   assign rsp_midi_channel  = result_ff.midi_channel;
   assign rsp_track_end     = result_ff.track_end;

endmodule

// File: sv/msci_step.sv
// Command decode and channel state update for one item; purely combinational.
// Depends on msci_pkg for the state, item, config and result types.
module msci_step
   import msci_pkg::*;
(
   input  cfg_type        cfg,
   input  chan_state_type cur,
   input  item_type       item,
   output chan_state_type nxt,
   output result_type     res
);

   logic [7:0]          op;
   logic [4:0]          tick_cnt;
   logic [12:0]         tick_prod;
   logic [LEN_W-1:0]    ticks;
   logic [TICK_W:0]     elapsed_sum;
   logic [TICK_W-1:0]   elapsed_sat;
   logic [TICK_W:0]     pending_sum;
   logic [TICK_W-1:0]   pending_sat;
   logic signed [17:0]  note_sum;
   logic [NOTE_W-1:0]   note_clamped;
   logic                start_ram;
   logic [ADDR_W-1:0]   start_pos;
   logic [ADDR_W-1:0]   call_ptr;
   logic [ADDR_W-1:0]   call_pos;
   logic [ADDR_W-1:0]   pos1;
   logic [ADDR_W-1:0]   pos2;
   logic [ADDR_W-1:0]   pos3;
   logic [ADDR_W-1:0]   oct_set;
   logic                rep_open_lv;
   logic                rep_close_lv;
   logic [RCNT_W-1:0]   rep_cnt;
   logic [1:0]          macro_dec;

   assign op = item.op_byte;

   // Note and rest length share one small multiplier: (low nibble + 1) * speed * 5
   assign tick_cnt  = {1'b0, op[3:0]} + 5'd1;
   assign tick_prod = 13'(tick_cnt * cur.speed_factor);
   assign ticks     = 15'({tick_prod, 2'b00} + {2'b00, tick_prod});

   // Saturating tick accumulators
   assign elapsed_sum = {1'b0, cur.elapsed_ticks} + {3'b000, ticks};
   assign elapsed_sat = elapsed_sum[TICK_W] ? DELAY_MAX : elapsed_sum[TICK_W-1:0];
   assign pending_sum = {1'b0, cur.pending_delay} + {3'b000, ticks};
   assign pending_sat = pending_sum[TICK_W] ? DELAY_MAX : pending_sum[TICK_W-1:0];

   // Note number: nibble + octave + transpose + 12 + adjust, clamped to 0..127
   assign note_sum = $signed({14'b0, op[7:4]})
                   + $signed({{2{cur.octave_offset[15]}}, cur.octave_offset})
                   + $signed({{10{cur.transpose_amount[7]}}, cur.transpose_amount})
                   + 18'sd12
                   + $signed({{2{cur.octave_adjust[15]}}, cur.octave_adjust});

   always_comb begin
      priority if (note_sum < 18'sd0) begin
         note_clamped = '0;
      end else if (note_sum > 18'sd127) begin
         note_clamped = 7'd127;
      end else begin
         note_clamped = note_sum[NOTE_W-1:0];
      end
   end

   // Pointer mapping: ROM pointers drop the bank base, RAM pointers rebase on the header
   assign start_ram = (item.start_pointer >= RAM_PTR_BASE);
   assign start_pos = start_ram ? (item.start_pointer - RAM_PTR_BASE + cfg.ram_base)
                                : (item.start_pointer - cfg.bank_base);
   assign call_ptr  = {item.arg_high, item.arg_low};
   assign call_pos  = cur.ram_mode ? (call_ptr - RAM_PTR_BASE + cfg.ram_base)
                                   : (call_ptr - cfg.bank_base);

   assign pos1 = cur.position + 16'd1;
   assign pos2 = cur.position + 16'd2;
   assign pos3 = cur.position + 16'd3;

   // Octave set: (op - 0xD0) * 12
   assign oct_set = {10'b0, op[2:0], 3'b000} + {11'b0, op[2:0], 2'b00};

   // Repeat level selection
   assign rep_open_lv  = ~cur.repeat_count[0][RCNT_W-1];
   assign rep_close_lv = ~cur.repeat_count[1][RCNT_W-1];
   assign rep_cnt      = cur.repeat_count[rep_close_lv];
   assign macro_dec    = cur.macro_level - 2'd1;

   // State update
   always_comb begin
      nxt               = cur;
      res               = '0;
      res.note_valid    = 1'b0;
      if (item.kind == KIND_START) begin
         nxt.track_index      = item.channel;
         if (item.new_song) begin
            nxt.program_number = '0;
         end
         nxt.first_flag       = 1'b1;
         nxt.speed_factor     = 8'd1;
         nxt.pending_delay    = '0;
         nxt.elapsed_ticks    = '0;
         nxt.transpose_amount = '0;
         nxt.octave_adjust    = '0;
         nxt.octave_offset    = (item.channel == NOISE_TRACK) ? NOISE_OCTAVE : '0;
         nxt.macro_level      = '0;
         nxt.repeat_count     = {REP_INACTIVE, REP_INACTIVE};
         nxt.ram_mode         = start_ram;
         nxt.position         = start_pos;
         nxt.ended            = (cfg.time_limit == '0);
      end else if (!cur.ended) begin
         priority if (op < OP_REST_FIRST) begin
            res.note_valid    = 1'b1;
            res.note_number   = note_clamped;
            res.note_length   = ticks;
            res.delay_before  = cur.pending_delay;
            res.program_first = cur.first_flag;
            nxt.first_flag    = 1'b0;
            nxt.pending_delay = '0;
            nxt.elapsed_ticks = elapsed_sat;
            nxt.position      = pos1;
         end else if (op <= OP_REST_LAST) begin
            nxt.pending_delay = pending_sat;
            nxt.elapsed_ticks = elapsed_sat;
            nxt.position      = pos1;
         end else if (op <= OP_OCT_SET_END) begin
            nxt.octave_offset = oct_set;
            nxt.position      = pos1;
         end else if (op == OP_OCT_UP) begin
            nxt.octave_offset = cur.octave_offset + OCTAVE_STEP;
            nxt.position      = pos1;
         end else if (op == OP_OCT_DOWN) begin
            nxt.octave_offset = cur.octave_offset - OCTAVE_STEP;
            nxt.position      = pos1;
         end else if (op == OP_TRANSPOSE) begin
            nxt.transpose_amount = item.arg_low;
            nxt.position         = pos2;
         end else if (op == OP_OCT_ADJUST) begin
            nxt.octave_adjust = cur.octave_adjust
                              + {{8{item.arg_low[7]}}, item.arg_low};
            nxt.position      = pos2;
         end else if (op == OP_SPEED) begin
            nxt.speed_factor = item.arg_low;
            nxt.position     = pos2;
         end else if (op == OP_DUTY) begin
            if (cfg.nes_mode) begin
               nxt.program_number = (item.arg_low >= PROG_LIMIT) ? '0
                                                                 : item.arg_low[PROG_W-1:0];
               nxt.first_flag     = 1'b1;
            end
            nxt.position = pos2;
         end else if (op == OP_SKIP1) begin
            nxt.position = pos1;
         end else if (op == OP_REP_OPEN) begin
            // a third open overwrites level two
            nxt.repeat_count[rep_open_lv] = {1'b0, item.arg_low};
            nxt.repeat_point[rep_open_lv] = pos2;
            nxt.position                  = pos2;
         end else if (op == OP_REP_CLOSE) begin
            if (!rep_cnt[RCNT_W-1] && (rep_cnt > 9'd1)) begin
               nxt.position                   = cur.repeat_point[rep_close_lv];
               nxt.repeat_count[rep_close_lv] = rep_cnt - 9'd1;
            end else begin
               nxt.repeat_count[rep_close_lv] = REP_INACTIVE;
               nxt.position                   = pos1;
            end
         end else if (op == OP_CALL) begin
            if (cur.macro_level < 2'd2) begin
               nxt.macro_return[cur.macro_level[0]] = pos3;
               nxt.position                         = call_pos;
               nxt.macro_level                      = cur.macro_level + 2'd1;
            end else begin
               nxt.ended = 1'b1;
            end
         end else if (op == OP_RETURN) begin
            if (cur.macro_level == 2'd1 || cur.macro_level == 2'd2) begin
               nxt.macro_level = macro_dec;
               nxt.position    = cur.macro_return[macro_dec[0]];
            end else begin
               nxt.ended = 1'b1;
            end
         end else if (op == OP_END || op == OP_END_ALT) begin
            nxt.ended = 1'b1;
         end else begin
            nxt.position = pos2;
         end
         // track time limit
         if (nxt.elapsed_ticks >= cfg.time_limit) begin
            nxt.ended = 1'b1;
         end
      end
      res.fetch_address = nxt.position;
      res.instrument    = nxt.program_number;
      res.midi_channel  = (nxt.track_index == NOISE_TRACK) ? NOISE_MIDI_CH
                                                          : {2'b00, nxt.track_index};
      res.track_end     = nxt.ended;
   end

endmodule

// File: sv/msci_checker.sv
// Port-level checks for the music sequence command interpreter, bound to the top level.
// Depends on msci_pkg and music_sequence_command_interpreter_top.
module msci_checker
   import msci_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [ADDR_W-1:0] rsp_fetch_address,
   input logic              rsp_note_valid,
   input logic [NOTE_W-1:0] rsp_note_number,
   input logic [LEN_W-1:0]  rsp_note_length,
   input logic [TICK_W-1:0] rsp_delay_before,
   input logic              rsp_program_first,
   input logic [3:0]        rsp_midi_channel
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Requests only back up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result");

   // A request taken with the output empty is registered, then shows as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("result missing after request");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_fetch_address)
                                    && $stable(rsp_note_valid)))
      else $error("stalled result changed");

   // Non-note results carry clear note fields and a legal channel
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_note_valid) |-> (rsp_note_number == '0 && rsp_note_length == '0
         && rsp_delay_before == '0 && !rsp_program_first
         && (rsp_midi_channel <= 4'd3 || rsp_midi_channel == NOISE_MIDI_CH)))
      else $error("note fields set without a note");

endmodule

bind music_sequence_command_interpreter_top msci_checker u_msci_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_fetch_address (rsp_fetch_address),
   .rsp_note_valid    (rsp_note_valid),
   .rsp_note_number   (rsp_note_number),
   .rsp_note_length   (rsp_note_length),
   .rsp_delay_before  (rsp_delay_before),
   .rsp_program_first (rsp_program_first),
   .rsp_midi_channel  (rsp_midi_channel)
);

// File: verif/msci_result_checker.sv
// Result checker for the music sequence command interpreter: watches the request,
// result and register ports, predicts each result and compares it field by field.
// Depends on msci_pkg only.
module msci_result_checker
   import msci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_kind,
   input  logic [1:0]            req_channel,
   input  logic                  req_new_song,
   input  logic [ADDR_W-1:0]     req_start_pointer,
   input  logic [7:0]            req_op_byte,
   input  logic [7:0]            req_arg_low,
   input  logic [7:0]            req_arg_high,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [ADDR_W-1:0]     rsp_fetch_address,
   input  logic                  rsp_note_valid,
   input  logic [NOTE_W-1:0]     rsp_note_number,
   input  logic [LEN_W-1:0]      rsp_note_length,
   input  logic [TICK_W-1:0]     rsp_delay_before,
   input  logic                  rsp_program_first,
   input  logic [PROG_W-1:0]     rsp_instrument,
   input  logic [3:0]            rsp_midi_channel,
   input  logic                  rsp_track_end,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    pending_results,
   output logic                  track_over
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] OP_OCT_SET_FIRST = OP_REST_LAST + 8'd1;
   localparam int         TICKS_PER_STEP   = 5;
   localparam int         NOTE_TOP         = 127;

   // Shadow copies of the channel state and the register file
   cfg_type        cfg;
   chan_state_type chan;
   result_type     expected_results[$];

   // Sequence pointer to bank offset, ROM or RAM mapping by current mode
   function automatic logic [ADDR_W-1:0] map_pointer(logic [ADDR_W-1:0] ptr);
      if (chan.ram_mode) begin
         return ptr - RAM_PTR_BASE + cfg.ram_base;
      end
      return ptr - cfg.bank_base;
   endfunction

   // Tick accumulation saturates at the top of the counter
   function automatic logic [TICK_W-1:0] add_ticks(logic [TICK_W-1:0] base, logic [31:0] ticks);
      logic [31:0] sum;
      sum = 32'(base) + ticks;
      return (sum > 32'(DELAY_MAX)) ? DELAY_MAX : sum[TICK_W-1:0];
   endfunction

   // Applies one request to the shadow state and returns the result it should produce
   function automatic result_type interpret_item(item_type it);
      result_type        res;
      logic [7:0]        op;
      logic [31:0]       ticks;
      int                pitch;
      int                lv;
      res = '0;
      op  = it.op_byte;
      if (it.kind == KIND_START) begin
         chan.track_index = it.channel;
         if (it.new_song) begin
            chan.program_number = '0;
         end
         chan.first_flag       = 1'b1;
         chan.speed_factor     = 8'd1;
         chan.pending_delay    = '0;
         chan.elapsed_ticks    = '0;
         chan.transpose_amount = '0;
         chan.octave_adjust    = '0;
         chan.octave_offset    = (it.channel == NOISE_TRACK) ? NOISE_OCTAVE : '0;
         chan.macro_level      = '0;
         chan.repeat_count     = {REP_INACTIVE, REP_INACTIVE};
         chan.ram_mode         = (it.start_pointer >= RAM_PTR_BASE);
         chan.position         = map_pointer(it.start_pointer);
         chan.ended            = (chan.elapsed_ticks >= cfg.time_limit);
      end else if (!chan.ended) begin
         if (op < OP_REST_FIRST) begin
            // note: high nibble is pitch, low nibble is length
            pitch = int'(op[7:4]) + int'($signed(chan.octave_offset))
                  + int'($signed(chan.transpose_amount)) + int'(OCTAVE_STEP)
                  + int'($signed(chan.octave_adjust));
            if (pitch < 0) pitch = 0;
            if (pitch > NOTE_TOP) pitch = NOTE_TOP;
            ticks = (32'(op[3:0]) + 32'd1) * 32'(chan.speed_factor) * TICKS_PER_STEP;
            res.note_valid     = 1'b1;
            res.note_number    = pitch[NOTE_W-1:0];
            res.note_length    = ticks[LEN_W-1:0];
            res.delay_before   = chan.pending_delay;
            res.program_first  = chan.first_flag;
            chan.first_flag    = 1'b0;
            chan.pending_delay = '0;
            chan.elapsed_ticks = add_ticks(chan.elapsed_ticks, ticks);
            chan.position      = chan.position + 16'd1;
         end else if (op <= OP_REST_LAST) begin
            ticks = (32'(op - OP_REST_FIRST) + 32'd1) * 32'(chan.speed_factor)
                  * TICKS_PER_STEP;
            chan.pending_delay = add_ticks(chan.pending_delay, ticks);
            chan.elapsed_ticks = add_ticks(chan.elapsed_ticks, ticks);
            chan.position      = chan.position + 16'd1;
         end else if (op <= OP_OCT_SET_END) begin
            chan.octave_offset = 16'(op - OP_OCT_SET_FIRST) * OCTAVE_STEP;
            chan.position      = chan.position + 16'd1;
         end else begin
            case (op)
               OP_OCT_UP: begin
                  chan.octave_offset = chan.octave_offset + OCTAVE_STEP;
                  chan.position      = chan.position + 16'd1;
               end
               OP_OCT_DOWN: begin
                  chan.octave_offset = chan.octave_offset - OCTAVE_STEP;
                  chan.position      = chan.position + 16'd1;
               end
               OP_TRANSPOSE: begin
                  chan.transpose_amount = it.arg_low;
                  chan.position         = chan.position + 16'd2;
               end
               OP_OCT_ADJUST: begin
                  chan.octave_adjust = chan.octave_adjust + {{8{it.arg_low[7]}}, it.arg_low};
                  chan.position      = chan.position + 16'd2;
               end
               OP_SPEED: begin
                  chan.speed_factor = it.arg_low;
                  chan.position     = chan.position + 16'd2;
               end
               OP_DUTY: begin
                  if (cfg.nes_mode) begin
                     chan.program_number = (it.arg_low >= PROG_LIMIT) ? '0 : it.arg_low[6:0];
                     chan.first_flag     = 1'b1;
                  end
                  chan.position = chan.position + 16'd2;
               end
               OP_SKIP1: begin
                  chan.position = chan.position + 16'd1;
               end
               OP_REP_OPEN: begin
                  // with both levels open, the inner one is overwritten
                  lv = (chan.repeat_count[0] == REP_INACTIVE) ? 0 : 1;
                  chan.repeat_count[lv] = {1'b0, it.arg_low};
                  chan.repeat_point[lv] = chan.position + 16'd2;
                  chan.position         = chan.position + 16'd2;
               end
               OP_REP_CLOSE: begin
                  lv = (chan.repeat_count[1] == REP_INACTIVE) ? 0 : 1;
                  if (chan.repeat_count[lv] != REP_INACTIVE && chan.repeat_count[lv] > 1) begin
                     chan.position         = chan.repeat_point[lv];
                     chan.repeat_count[lv] = chan.repeat_count[lv] - 9'd1;
                  end else begin
                     chan.repeat_count[lv] = REP_INACTIVE;
                     chan.position         = chan.position + 16'd1;
                  end
               end
               OP_CALL: begin
                  if (chan.macro_level < 2) begin
                     chan.macro_return[chan.macro_level] = chan.position + 16'd3;
                     chan.position    = map_pointer({it.arg_high, it.arg_low});
                     chan.macro_level = chan.macro_level + 2'd1;
                  end else begin
                     chan.ended = 1'b1;
                  end
               end
               OP_RETURN: begin
                  if (chan.macro_level == 2'd1 || chan.macro_level == 2'd2) begin
                     chan.macro_level = chan.macro_level - 2'd1;
                     chan.position    = chan.macro_return[chan.macro_level];
                  end else begin
                     chan.ended = 1'b1;
                  end
               end
               OP_END, OP_END_ALT: begin
                  chan.ended = 1'b1;
               end
               default: begin
                  chan.position = chan.position + 16'd2;
               end
            endcase
         end
         if (chan.elapsed_ticks >= cfg.time_limit) chan.ended = 1'b1;
      end
      res.fetch_address = chan.position;
      res.instrument    = chan.program_number;
      res.midi_channel  = (chan.track_index == NOISE_TRACK) ? NOISE_MIDI_CH
                                                           : {2'b00, chan.track_index};
      res.track_end     = chan.ended;
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Register writes, result compare, then prediction for a new request
   always @(posedge clock) begin : scoreboard
      result_type want;
      if (reset) begin
         cfg.bank_base  = BANK_BASE_RESET;
         cfg.ram_base   = RAM_BASE_RESET;
         cfg.nes_mode   = 1'b0;
         cfg.time_limit = TIME_LIMIT_RESET;
         chan           = STATE_RESET;
         expected_results.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BANK_BASE:  cfg.bank_base  = csr_data[ADDR_W-1:0];
               CSR_RAM_BASE:   cfg.ram_base   = csr_data[ADDR_W-1:0];
               CSR_NES_MODE:   cfg.nes_mode   = csr_data[0];
               CSR_TIME_LIMIT: cfg.time_limit = csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result, fetch_address %0d", rsp_fetch_address);
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("fetch_address", want.fetch_address, rsp_fetch_address);
               check_field("note_valid", want.note_valid, rsp_note_valid);
               check_field("note_number", want.note_number, rsp_note_number);
               check_field("note_length", want.note_length, rsp_note_length);
               check_field("delay_before", want.delay_before, rsp_delay_before);
               check_field("program_first", want.program_first, rsp_program_first);
               check_field("instrument", want.instrument, rsp_instrument);
               check_field("midi_channel", want.midi_channel, rsp_midi_channel);
               check_field("track_end", want.track_end, rsp_track_end);
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(interpret_item('{kind: req_kind,
                                                         channel: req_channel,
                                                         new_song: req_new_song,
                                                         start_pointer: req_start_pointer,
                                                         op_byte: req_op_byte,
                                                         arg_low: req_arg_low,
                                                         arg_high: req_arg_high}));
         end
      end
      pending_results <= expected_results.size();
      track_over      <= chan.ended;
   end

endmodule

// File: verif/tb_top.sv
// Testbench top for the music sequence command interpreter: clock, reset, request and
// register stimulus, random result backpressure, watchdog and verdict.
// Depends on msci_pkg, music_sequence_command_interpreter_top and msci_result_checker.
module tb_top
   import msci_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [7:0] OP_SPARE = OP_SPEED + 8'd1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [1:0]            req_channel;
   logic                  req_new_song;
   logic [ADDR_W-1:0]     req_start_pointer;
   logic [7:0]            req_op_byte;
   logic [7:0]            req_arg_low;
   logic [7:0]            req_arg_high;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ADDR_W-1:0]     rsp_fetch_address;
   logic                  rsp_note_valid;
   logic [NOTE_W-1:0]     rsp_note_number;
   logic [LEN_W-1:0]      rsp_note_length;
   logic [TICK_W-1:0]     rsp_delay_before;
   logic                  rsp_program_first;
   logic [PROG_W-1:0]     rsp_instrument;
   logic [3:0]            rsp_midi_channel;
   logic                  rsp_track_end;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    failures;
   int                    pending_results;
   logic                  track_over;
   int                    quiet_cycles = 0;
   int                    burst_left = 0;

   music_sequence_command_interpreter_top dut (.*);

   msci_result_checker checker_inst (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: ends the run when nothing moves on any port for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result backpressure: short stalls mostly, a few long ones, some long free runs
   initial begin : rsp_backpressure
      int free_len;
      int hold_len;
      rsp_stall <= 1'b0;
      forever begin
         free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 6);
         hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(1, 3);
         repeat (free_len) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (hold_len) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Gap before the next request: none inside a burst, else mostly short
   function automatic int next_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         burst_left = $urandom_range(20, 40);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic item_type cmd_item(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
      item_type it;
      it.kind          = KIND_CMD;
      it.channel       = 2'($urandom);
      it.new_song      = 1'($urandom);
      it.start_pointer = 16'($urandom);
      it.op_byte       = op;
      it.arg_low       = lo;
      it.arg_high      = hi;
      return it;
   endfunction

   function automatic item_type start_item(logic [1:0] ch, logic fresh, logic [ADDR_W-1:0] ptr);
      item_type it;
      it               = cmd_item(8'($urandom), 8'($urandom), 8'($urandom));
      it.kind          = KIND_START;
      it.channel       = ch;
      it.new_song      = fresh;
      it.start_pointer = ptr;
      return it;
   endfunction

   // Random request: well-formed command mix with some raw noise; restart on end
   function automatic item_type random_item(logic over);
      int         pick;
      logic [7:0] op;
      logic [7:0] lo;
      lo = 8'($urandom);
      if (over || $urandom_range(0, 99) < 4) begin
         return start_item(2'($urandom), 1'($urandom),
                           $urandom_range(0, 1) ? 16'($urandom_range(0, RAM_PTR_BASE - 1))
                                                : 16'($urandom_range(RAM_PTR_BASE, 16'hFFFF)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) op = 8'($urandom);
      else if (pick < 40) op = 8'($urandom_range(0, OP_REST_FIRST - 1));
      else if (pick < 50) op = 8'($urandom_range(OP_REST_FIRST, OP_REST_LAST));
      else if (pick < 55) op = 8'($urandom_range(OP_REST_LAST + 1, OP_OCT_SET_END));
      else if (pick < 58) op = OP_OCT_UP;
      else if (pick < 61) op = OP_OCT_DOWN;
      else if (pick < 64) op = OP_TRANSPOSE;
      else if (pick < 67) op = OP_OCT_ADJUST;
      else if (pick < 71) begin
         op = OP_SPEED;
         if ($urandom_range(0, 4) != 0) lo = 8'($urandom_range(0, 6));
      end
      else if (pick < 74) op = OP_DUTY;
      else if (pick < 76) op = OP_SKIP1;
      else if (pick < 81) begin
         op = OP_REP_OPEN;
         if ($urandom_range(0, 3) != 0) lo = 8'($urandom_range(0, 4));
      end
      else if (pick < 87) op = OP_REP_CLOSE;
      else if (pick < 91) op = OP_CALL;
      else if (pick < 95) op = OP_RETURN;
      else if (pick < 97) op = $urandom_range(0, 1) ? OP_END : OP_END_ALT;
      else op = 8'($urandom_range(OP_OCT_ADJUST + 1, OP_SPEED - 1));
      return cmd_item(op, lo, 8'($urandom));
   endfunction

   // Presents one request after a gap and returns at the edge that takes it
   task automatic send_request(item_type it, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= it.kind;
      req_channel       <= it.channel;
      req_new_song      <= it.new_song;
      req_start_pointer <= it.start_pointer;
      req_op_byte       <= it.op_byte;
      req_arg_low       <= it.arg_low;
      req_arg_high      <= it.arg_high;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic command(logic [7:0] op, logic [7:0] lo = 8'h00, logic [7:0] hi = 8'h00);
      send_request(cmd_item(op, lo, hi), next_gap());
   endtask

   task automatic start_track(logic [1:0] ch, logic fresh, logic [ADDR_W-1:0] ptr);
      send_request(start_item(ch, fresh, ptr), next_gap());
   endtask

   // Register write; the caller lowers csr_valid after the last one
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(logic [ADDR_W-1:0] bank, logic [ADDR_W-1:0] ram,
                                 logic nes, logic [TICK_W-1:0] limit);
      write_reg(CSR_BANK_BASE, CSR_DATA_W'(bank));
      write_reg(CSR_RAM_BASE, CSR_DATA_W'(ram));
      write_reg(CSR_NES_MODE, CSR_DATA_W'(nes));
      write_reg(CSR_TIME_LIMIT, CSR_DATA_W'(limit));
      csr_valid <= 1'b0;
   endtask

   // Drain: every expected result back, then a few quiet cycles
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      item_type          it;
      logic              ignored;
      int                counted;
      int                quota;
      logic [ADDR_W-1:0] bank;
      logic [ADDR_W-1:0] ram;
      logic              nes;
      logic [TICK_W-1:0] limit;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_kind          <= KIND_START;
      req_channel       <= '0;
      req_new_song      <= 1'b0;
      req_start_pointer <= '0;
      req_op_byte       <= '0;
      req_arg_low       <= '0;
      req_arg_high      <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_BANK_BASE;
      csr_data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: every command, the extremes and the corner cases
      apply_settings(BANK_BASE_RESET, 16'h0100, 1'b1, TIME_LIMIT_RESET);
      command({4'h0, 4'h0});                  // no track started yet: ignored
      start_track(2'd0, 1'b1, 16'h4123);
      command(OP_REST_FIRST);
      command(OP_REST_LAST);
      command({4'hB, 4'hF});                  // picks up rest delay and program flag
      command(OP_OCT_SET_END);
      command(OP_TRANSPOSE, 8'h7F);
      command({4'hB, 4'h5});                  // clamps at the top
      command(OP_OCT_UP);
      command(OP_OCT_DOWN);
      command(OP_TRANSPOSE, 8'h80);
      command(OP_OCT_ADJUST, 8'h80);
      command({4'h0, 4'h0});                  // clamps at zero
      command(OP_SPEED, 8'h00);
      command({4'h3, 4'hF});                  // speed zero: zero length
      command(OP_SPEED, 8'hFF);
      command(OP_DUTY, 8'h85);
      command(OP_DUTY, 8'h7F);
      command(OP_SKIP1);
      command(OP_SPARE, 8'hFF, 8'hFF);
      command(OP_REP_OPEN, 8'd2);
      command(OP_REP_OPEN, 8'd3);
      command(OP_REP_OPEN, 8'hFF);            // both levels busy: inner overwritten
      command(OP_REP_CLOSE);
      command(OP_CALL, 8'h00, 8'h40);
      command(OP_CALL, 8'hFF, 8'hFF);
      command(OP_CALL, 8'h34, 8'h12);         // third nesting ends the track
      start_track(NOISE_TRACK, 1'b0, 16'hFFFF);
      command(OP_RETURN);                     // return with no call ends the track
      start_track(2'd2, 1'b0, RAM_PTR_BASE);
      command(OP_CALL, 8'h00, 8'hDA);
      command(OP_CALL, 8'h00, 8'hE0);         // second call while RAM-mapped
      command(OP_RETURN);
      command(OP_RETURN);
      command(OP_REP_CLOSE);                  // close with no open loop
      command(OP_END);
      start_track(2'd1, 1'b1, 16'h0000);
      command(OP_END_ALT);
      settle();

      // Random phases, each under its own register setting
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               bank = '1; ram = '1; nes = 1'b1; limit = DELAY_MAX; quota = 100;
            end
            1: begin
               bank = '0; ram = '0; nes = 1'b0; limit = '0; quota = 15;
            end
            2: begin
               bank = 16'($urandom); ram = 16'($urandom); nes = 1'b1; limit = 17'd1;
               quota = 20;
            end
            3: begin
               bank = 16'($urandom); ram = 16'($urandom); nes = 1'($urandom);
               limit = 17'($urandom_range(200, 20000)); quota = 120;
            end
            4: begin
               bank = '0; ram = '0; nes = 1'b1; limit = DELAY_MAX; quota = 120;
            end
            default: begin
               bank = BANK_BASE_RESET; ram = RAM_BASE_RESET; nes = 1'b0;
               limit = TIME_LIMIT_RESET; quota = 100;
            end
         endcase
         apply_settings(bank, ram, nes, limit);
         counted = 0;
         while (counted < quota) begin
            it      = random_item(track_over);
            ignored = (it.kind == KIND_CMD) && track_over;
            send_request(it, next_gap());
            if (!ignored) counted++;
         end
         settle();
      end

      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: music_sequence_command_interpreter_top.f
sv/msci_pkg.sv
sv/msci_step.sv
sv/music_sequence_command_interpreter_top.sv
sv/msci_checker.sv
verif/msci_result_checker.sv
verif/tb_top.sv
